[sv/image_resize_nearest_bilinear_defines.svh]
// Assertion macros shared by the image resizer RTL.
`ifndef IMAGE_RESIZE_NEAREST_BILINEAR_DEFINES_SVH
`define IMAGE_RESIZE_NEAREST_BILINEAR_DEFINES_SVH

`ifndef SYNTHESIS
`define IRSZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IRSZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IRSZ_ASSERT(lbl, prop, msg)
`define IRSZ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/irsz_pkg.sv]
// Types and constants of the image resizer.
`default_nettype none

package irsz_pkg;

  localparam int PIX_W       = 8;   // pixel value
  localparam int CRD_W       = 10;  // input coordinate
  localparam int DIM_W       = 11;  // image dimension register
  localparam int ADDR_FULL_W = 22;  // row * width + column before range check
  localparam int DEN_W       = 12;  // divisor: twice a dimension
  localparam int CFG_IDX_W   = 3;
  localparam int IN_DATA_W   = 32;  // 28 payload bits padded to whole bytes

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT,
    CFG_BILINEAR
  } cfg_idx_e;

  typedef enum logic [0:0] {
    REQ_LOAD,
    REQ_COMPUTE
  } req_e;

  typedef enum logic [1:0] {
    BL_TOP,
    BL_BOT,
    BL_VERT
  } blend_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_WR,
    ST_CRD_MUL,
    ST_CRD_DIV,
    ST_CRD_WAIT,
    ST_ROW_MUL,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

[sv/irsz_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module irsz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/irsz_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module irsz_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 12,
  parameter int QUO_W = 27
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic      [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  // numerator bits shift out at the top while quotient bits shift in below
  logic [QUO_W-1:0] sh_q, sh_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, sh_q[QUO_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    rem_d = rem_q;
    den_d = den_q;
    sh_d  = sh_q;
    if (start_i) begin
      cnt_d = CNT_W'(QUO_W);
      rem_d = DEN_W'(num_i[NUM_W-1:QUO_W]);
      den_d = den_i;
      sh_d  = num_i[QUO_W-1:0];
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_d  = {sh_q[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = sh_q;

endmodule

`default_nettype wire

[sv/image_resize_nearest_bilinear.sv]
// Image resizer top level: sequencer, shared multiplier, divider and source store.
// One beat at a time. A load beat writes one source pixel through a multiply and a write
// state. A compute beat gives one result beat: an out-of-range beat goes straight to the
// result state; otherwise each axis gets its coordinate, then nearest fetches one source
// pixel and bilinear fetches four and blends them. The time is set by the bit-serial
// divider, which runs at most once per axis, and by the single store port, which serves
// one read per row multiply, fetch and fetch wait; blends go one at a time through the
// shared multiplier. The store is not cleared: only pixels loaded since reset may be
// sampled. The next beat is taken while a result still waits in the output register.
`default_nettype none
`include "image_resize_nearest_bilinear_defines.svh"

module image_resize_nearest_bilinear #(
  parameter int MAX_PIXELS = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [irsz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [irsz_pkg::DIM_W-1:0]         cfg_data_i,
  // request stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [7:0] pixel_in, [17:8] x_coord, [27:18] y_coord, [31:28] zero
  input  wire logic [irsz_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] req_type
  input  wire logic                               s_axis_tuser_i,
  // result stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] pixel_out
  output logic      [irsz_pkg::PIX_W-1:0]         m_axis_tdata_o,
  // [0] out_of_range
  output logic                                    m_axis_tuser_o
);

  localparam int PIX_W = irsz_pkg::PIX_W;
  localparam int CRD_W = irsz_pkg::CRD_W;
  localparam int DIM_W = irsz_pkg::DIM_W;
  localparam int AFW   = irsz_pkg::ADDR_FULL_W;
  localparam int DEN_W = irsz_pkg::DEN_W;
  localparam int MB    = (FRAC_BITS > DIM_W) ? FRAC_BITS : DIM_W;
  localparam int PW    = DIM_W + MB;
  localparam int QW    = DIM_W + FRAC_BITS;
  localparam int NUMW  = AFW + FRAC_BITS;
  localparam int VW    = FRAC_BITS + PIX_W + 1;
  localparam int AW    = $clog2(MAX_PIXELS);

  irsz_pkg::state_e state_q, state_d;

  logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
  logic             bil_q;
  logic [DIM_W-1:0] sw, sh, dw, dh;

  logic [PIX_W-1:0] in_pix_q, in_pix_d;
  logic [CRD_W-1:0] in_x_q, in_x_d, in_y_q, in_y_d;
  logic             axis_q, axis_d;
  logic [PW-1:0]    prod_q, prod_d;
  logic [QW-1:0]    crd_q [2];
  logic [QW-1:0]    crd_d [2];
  logic [1:0]       k_q, k_d;
  logic [PIX_W-1:0] pix_q [4];
  logic [PIX_W-1:0] pix_d [4];
  logic             oob_q, oob_d;
  irsz_pkg::blend_e j_q, j_d;
  logic [PIX_W-1:0] top_q, top_d, bot_q, bot_d;
  logic [PIX_W-1:0] res_pix_q, res_pix_d;
  logic             res_oor_q, res_oor_d;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;
  logic             out_oor_q, out_oor_d;

  logic             div_start;
  logic [NUMW-1:0]  div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic [QW-1:0]    div_quo;

  logic             ram_we;
  logic [AFW-1:0]   addr_full;
  logic [PIX_W-1:0] ram_rdata;

  // combinational helpers
  logic [CRD_W-1:0]     d_sel;
  logic [DIM_W-1:0]     dd_sel, ss_sel, s_m1, d_m1;
  logic [DIM_W-1:0]     ix, iy, rx, by, col, row;
  logic [DIM_W:0]       ix_p1, iy_p1;
  logic [FRAC_BITS-1:0] frac_x, frac_y, fr;
  logic [DIM_W-1:0]     mul_a;
  logic [MB-1:0]        mul_b;
  logic [AFW-1:0]       p22;
  logic [QW-1:0]        ctop;
  logic [PIX_W-1:0]     bb, ee, adiff, fetched, blend_res;
  logic                 ee_ge;
  logic [VW-1:0]        bv, pterm, half, vsum;
  logic                 s_hs;
  logic [CRD_W-1:0]     s_x, s_y;

  assign sw = (sw_q == '0) ? DIM_W'(1) : sw_q;
  assign sh = (sh_q == '0) ? DIM_W'(1) : sh_q;
  assign dw = (dw_q == '0) ? DIM_W'(1) : dw_q;
  assign dh = (dh_q == '0) ? DIM_W'(1) : dh_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == irsz_pkg::ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign s_x             = s_axis_tdata_i[PIX_W+CRD_W-1:PIX_W];
  assign s_y             = s_axis_tdata_i[PIX_W+2*CRD_W-1:PIX_W+CRD_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= DIM_W'(1);
      sh_q  <= DIM_W'(1);
      dw_q  <= DIM_W'(1);
      dh_q  <= DIM_W'(1);
      bil_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        irsz_pkg::CFG_SRC_WIDTH:  sw_q  <= cfg_data_i;
        irsz_pkg::CFG_SRC_HEIGHT: sh_q  <= cfg_data_i;
        irsz_pkg::CFG_DST_WIDTH:  dw_q  <= cfg_data_i;
        irsz_pkg::CFG_DST_HEIGHT: dh_q  <= cfg_data_i;
        irsz_pkg::CFG_BILINEAR:   bil_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // per-axis operands
  always_comb begin
    d_sel  = axis_q ? in_y_q : in_x_q;
    dd_sel = axis_q ? dh : dw;
    ss_sel = axis_q ? sh : sw;
    s_m1   = ss_sel - 1'b1;
    d_m1   = dd_sel - 1'b1;
    p22    = prod_q[AFW-1:0];
    ctop   = {s_m1, {FRAC_BITS{1'b0}}};
  end

  // sample positions; right and bottom neighbors clamp to the last column / row
  always_comb begin
    ix     = bil_q ? crd_q[0][QW-1:FRAC_BITS] : crd_q[0][DIM_W-1:0];
    iy     = bil_q ? crd_q[1][QW-1:FRAC_BITS] : crd_q[1][DIM_W-1:0];
    frac_x = crd_q[0][FRAC_BITS-1:0];
    frac_y = crd_q[1][FRAC_BITS-1:0];
    ix_p1  = {1'b0, ix} + 1'b1;
    iy_p1  = {1'b0, iy} + 1'b1;
    rx     = (ix_p1 < {1'b0, sw}) ? ix_p1[DIM_W-1:0] : sw - 1'b1;
    by     = (iy_p1 < {1'b0, sh}) ? iy_p1[DIM_W-1:0] : sh - 1'b1;
    col    = k_q[0] ? rx : ix;
    row    = k_q[1] ? by : iy;
  end

  // blend operands and rounding
  always_comb begin
    case (j_q)
      irsz_pkg::BL_TOP: begin
        bb = pix_q[0];
        ee = pix_q[1];
        fr = frac_x;
      end
      irsz_pkg::BL_BOT: begin
        bb = pix_q[2];
        ee = pix_q[3];
        fr = frac_x;
      end
      default: begin
        bb = top_q;
        ee = bot_q;
        fr = frac_y;
      end
    endcase
    ee_ge     = (ee >= bb);
    adiff     = ee_ge ? ee - bb : bb - ee;
    bv        = {1'b0, bb, {FRAC_BITS{1'b0}}};
    pterm     = VW'(prod_q[FRAC_BITS+PIX_W-1:0]);
    half      = VW'(1) << (FRAC_BITS - 1);
    vsum      = ee_ge ? bv + pterm + half : bv - pterm + half;
    blend_res = vsum[FRAC_BITS+PIX_W-1:FRAC_BITS];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = sw;
    mul_b = MB'(in_y_q);
    case (state_q)
      irsz_pkg::ST_CRD_MUL: begin
        if (bil_q) begin
          mul_a = ss_sel;
          mul_b = MB'({d_sel, 1'b1});
        end else begin
          mul_a = s_m1;
          mul_b = MB'(d_sel);
        end
      end
      irsz_pkg::ST_ROW_MUL: begin
        mul_a = sw;
        mul_b = MB'(row);
      end
      irsz_pkg::ST_BLEND_MUL: begin
        mul_a = DIM_W'(adiff);
        mul_b = MB'(fr);
      end
      default: ;
    endcase
  end

  // one adder serves load and fetch addresses
  assign addr_full = p22 + AFW'(state_q == irsz_pkg::ST_LOAD_WR ? DIM_W'(in_x_q) : col);
  assign ram_we    = (state_q == irsz_pkg::ST_LOAD_WR) && ({1'b0, in_x_q} < sw) &&
                     ({1'b0, in_y_q} < sh) && (addr_full < AFW'(MAX_PIXELS));

  always_comb begin
    if (bil_q) begin
      div_num = {p22 - AFW'(dd_sel), {FRAC_BITS{1'b0}}};
      div_den = {1'b0, dd_sel} << 1;
    end else begin
      div_num = NUMW'({p22[AFW-2:0], 1'b0}) + NUMW'(d_m1);
      div_den = {1'b0, d_m1} << 1;
    end
    div_start = (state_q == irsz_pkg::ST_CRD_DIV) && !(bil_q && (p22 <= AFW'(dd_sel)));
  end

  assign fetched = oob_q ? '0 : ram_rdata;

  // sequencer
  always_comb begin
    state_d     = state_q;
    in_pix_d    = in_pix_q;
    in_x_d      = in_x_q;
    in_y_d      = in_y_q;
    axis_d      = axis_q;
    prod_d      = prod_q;
    crd_d       = crd_q;
    k_d         = k_q;
    pix_d       = pix_q;
    oob_d       = oob_q;
    j_d         = j_q;
    top_d       = top_q;
    bot_d       = bot_q;
    res_pix_d   = res_pix_q;
    res_oor_d   = res_oor_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_pix_d   = out_pix_q;
    out_oor_d   = out_oor_q;

    case (state_q)
      irsz_pkg::ST_IDLE: begin
        if (s_hs) begin
          in_pix_d = s_axis_tdata_i[PIX_W-1:0];
          in_x_d   = s_x;
          in_y_d   = s_y;
          axis_d   = 1'b0;
          if (s_axis_tuser_i == irsz_pkg::REQ_LOAD) begin
            state_d = irsz_pkg::ST_LOAD_MUL;
          end else if (({1'b0, s_x} >= dw) || ({1'b0, s_y} >= dh)) begin
            res_pix_d = '0;
            res_oor_d = 1'b1;
            state_d   = irsz_pkg::ST_RESULT;
          end else begin
            state_d = irsz_pkg::ST_CRD_MUL;
          end
        end
      end
      irsz_pkg::ST_LOAD_MUL: begin
        prod_d  = PW'(mul_a) * PW'(mul_b);
        state_d = irsz_pkg::ST_LOAD_WR;
      end
      irsz_pkg::ST_LOAD_WR: begin
        state_d = irsz_pkg::ST_IDLE;
      end
      irsz_pkg::ST_CRD_MUL: begin
        prod_d = PW'(mul_a) * PW'(mul_b);
        if (!bil_q && (dd_sel == DIM_W'(1))) begin
          // single-pixel destination axis maps to source 0
          crd_d[axis_q] = '0;
          if (axis_q) begin
            k_d     = '0;
            state_d = irsz_pkg::ST_ROW_MUL;
          end else begin
            axis_d = 1'b1;
          end
        end else begin
          state_d = irsz_pkg::ST_CRD_DIV;
        end
      end
      irsz_pkg::ST_CRD_DIV: begin
        if (div_start) begin
          state_d = irsz_pkg::ST_CRD_WAIT;
        end else begin
          // sample position left of the first pixel center
          crd_d[axis_q] = '0;
          if (axis_q) begin
            k_d     = '0;
            state_d = irsz_pkg::ST_ROW_MUL;
          end else begin
            axis_d  = 1'b1;
            state_d = irsz_pkg::ST_CRD_MUL;
          end
        end
      end
      irsz_pkg::ST_CRD_WAIT: begin
        if (!div_busy) begin
          crd_d[axis_q] = (bil_q && (div_quo > ctop)) ? ctop : div_quo;
          if (axis_q) begin
            k_d     = '0;
            state_d = irsz_pkg::ST_ROW_MUL;
          end else begin
            axis_d  = 1'b1;
            state_d = irsz_pkg::ST_CRD_MUL;
          end
        end
      end
      irsz_pkg::ST_ROW_MUL: begin
        prod_d  = PW'(mul_a) * PW'(mul_b);
        state_d = irsz_pkg::ST_FETCH;
      end
      irsz_pkg::ST_FETCH: begin
        oob_d   = (addr_full >= AFW'(MAX_PIXELS));
        state_d = irsz_pkg::ST_FETCH_WAIT;
      end
      irsz_pkg::ST_FETCH_WAIT: begin
        pix_d[k_q] = fetched;
        if (!bil_q) begin
          res_pix_d = fetched;
          res_oor_d = 1'b0;
          state_d   = irsz_pkg::ST_RESULT;
        end else if (k_q == 2'd3) begin
          j_d     = irsz_pkg::BL_TOP;
          state_d = irsz_pkg::ST_BLEND_MUL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = irsz_pkg::ST_ROW_MUL;
        end
      end
      irsz_pkg::ST_BLEND_MUL: begin
        prod_d  = PW'(mul_a) * PW'(mul_b);
        state_d = irsz_pkg::ST_BLEND_ADD;
      end
      irsz_pkg::ST_BLEND_ADD: begin
        case (j_q)
          irsz_pkg::BL_TOP: begin
            top_d   = blend_res;
            j_d     = irsz_pkg::BL_BOT;
            state_d = irsz_pkg::ST_BLEND_MUL;
          end
          irsz_pkg::BL_BOT: begin
            bot_d   = blend_res;
            j_d     = irsz_pkg::BL_VERT;
            state_d = irsz_pkg::ST_BLEND_MUL;
          end
          default: begin
            res_pix_d = blend_res;
            res_oor_d = 1'b0;
            state_d   = irsz_pkg::ST_RESULT;
          end
        endcase
      end
      irsz_pkg::ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_pix_d   = res_pix_q;
          out_oor_d   = res_oor_q;
          state_d     = irsz_pkg::ST_IDLE;
        end
      end
      default: state_d = irsz_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irsz_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_pix_q  <= in_pix_d;
    in_x_q    <= in_x_d;
    in_y_q    <= in_y_d;
    axis_q    <= axis_d;
    prod_q    <= prod_d;
    crd_q     <= crd_d;
    k_q       <= k_d;
    pix_q     <= pix_d;
    oob_q     <= oob_d;
    j_q       <= j_d;
    top_q     <= top_d;
    bot_q     <= bot_d;
    res_pix_q <= res_pix_d;
    res_oor_q <= res_oor_d;
    out_pix_q <= out_pix_d;
    out_oor_q <= out_oor_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = out_oor_q;

  irsz_div #(
    .NUM_W (NUMW),
    .DEN_W (DEN_W),
    .QUO_W (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  irsz_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_full[AW-1:0]),
    .wdata_i (in_pix_q),
    .rdata_o (ram_rdata)
  );

  `IRSZ_ASSERT(a_div_start_idle, div_start |-> !div_busy, "divider restarted while busy")
  `IRSZ_ASSERT_NEXT(a_beat_leaves_idle, s_hs, state_q != irsz_pkg::ST_IDLE, "accepted beat lost")
  `IRSZ_ASSERT_NEXT(a_result_holds,
      (state_q == irsz_pkg::ST_RESULT) && out_valid_q && !m_axis_tready_i,
      state_q == irsz_pkg::ST_RESULT, "result overwrote a pending beat")
  `IRSZ_ASSERT(a_oor_zero, (out_valid_q && out_oor_q) |-> (out_pix_q == '0),
      "out of range result with nonzero pixel")

endmodule

`default_nettype wire
